// ===== design/msd_pkg.sv =====
`timescale 1ns / 1ps
package msd_pkg;

	localparam int INDEX_BITS = 12;
	localparam int N_BITS     = 13;

	localparam logic [N_BITS-1:0] RESET_LIST_SIZE = 13'd1626;
	localparam logic [11:0]       CRC_POLY        = 12'h987;
	localparam logic [3:0]        GROUP_WORDS     = 4'd12;
	localparam logic [3:0]        LONG_WORDS      = 4'd14;
	localparam logic [3:0]        MAX_POS         = 4'd15;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_LEN  = 3'd1;
	localparam logic [2:0] ST_RANGE    = 3'd2;
	localparam logic [2:0] ST_GROUP    = 3'd3;
	localparam logic [2:0] ST_CHECKSUM = 3'd4;

	localparam logic KIND_KEY    = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_MUL1,
		S_MUL2,
		S_MOD,
		S_CMP,
		S_CRC,
		S_KEY,
		S_CSUM,
		S_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic classify;
		logic mul1;
		logic mul2;
		logic mod_step;
		logic cmp_fail;
		logic crc_step;
		logic emit_key;
		logic emit_final;
	} cmd_t;

	typedef struct packed {
		logic group;
		logic last;
		logic mod_done;
		logic match;
		logic crc_done;
		logic slot_free;
	} stat_t;

	function automatic logic [11:0] crc_byte(input logic [11:0] crc, input logic [7:0] data);
		logic [11:0] c;
		c = crc ^ {data, 4'b0000};
		for (int b = 0; b < 8; b++) begin
			if (c[11]) begin
				c = {c[10:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[10:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [N_BITS-1:0] digit_diff(input logic [N_BITS-1:0] n,
			input logic [INDEX_BITS-1:0] a, input logic [INDEX_BITS-1:0] b);
		logic [N_BITS:0] t;
		t = {1'b0, n} + {2'b00, b} - {2'b00, a};
		if (b >= a) begin
			return {1'b0, b} - {1'b0, a};
		end else begin
			return t[N_BITS-1:0];
		end
	endfunction

	function automatic logic [1:0] pos_phase(input logic [3:0] pos);
		case (pos)
			4'd0, 4'd3, 4'd6, 4'd9:  pos_phase = 2'd0;
			4'd1, 4'd4, 4'd7, 4'd10: pos_phase = 2'd1;
			default:                 pos_phase = 2'd2;
		endcase
	endfunction

endpackage

// ===== design/msd_ctrl.sv =====
`timescale 1ns / 1ps
module msd_ctrl import msd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_d = S_CHECK;
			S_CHECK: begin
				if (st.group) state_d = S_MUL1;
				else if (st.last) state_d = S_CSUM;
				else state_d = S_IDLE;
			end
			S_MUL1:  state_d = S_MUL2;
			S_MUL2:  state_d = S_MOD;
			S_MOD:   if (st.mod_done) state_d = S_CMP;
			S_CMP: begin
				if (st.match) state_d = S_CRC;
				else if (st.last) state_d = S_CSUM;
				else state_d = S_IDLE;
			end
			S_CRC:   if (st.crc_done) state_d = S_KEY;
			S_KEY: begin
				if (st.slot_free) state_d = st.last ? S_CSUM : S_IDLE;
			end
			S_CSUM:  state_d = S_FIN;
			S_FIN:   if (st.slot_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_CHECK: cmd.classify = 1'b1;
			S_MUL1:  cmd.mul1 = 1'b1;
			S_MUL2:  cmd.mul2 = 1'b1;
			S_MOD:   cmd.mod_step = 1'b1;
			S_CMP:   cmd.cmp_fail = !st.match;
			S_CRC:   cmd.crc_step = 1'b1;
			S_KEY:   cmd.emit_key = st.slot_free;
			S_CSUM:  cmd.mul1 = 1'b1;
			S_FIN:   cmd.emit_final = st.slot_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== design/msd_datapath.sv =====
`timescale 1ns / 1ps
module msd_datapath import msd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [N_BITS-1:0]     cfg_data,
	input  logic [INDEX_BITS-1:0] in_index,
	input  logic                  in_last,
	input  cmd_t                  cmd,
	output stat_t                 st,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [47:0]           m_tdata,
	output logic                  m_tuser,
	output logic                  m_tlast
);

	logic [N_BITS-1:0]     n_q;
	logic [INDEX_BITS-1:0] w_q;
	logic                  last_q;
	logic [3:0]            pos_q;
	logic [INDEX_BITS-1:0] h_q [2];
	logic [11:0]           crc_q;
	logic [2:0]            err_q;
	logic [2*N_BITS-1:0]   prod_a_q;
	logic [2*N_BITS-1:0]   prod_nn_q;
	logic [N_BITS-1:0]     d2_q;
	logic [31:0]           v_q;
	logic [31:0]           vsh_q;
	logic [N_BITS-1:0]     rem_q;
	logic [4:0]            mcnt_q;
	logic [1:0]            bcnt_q;
	logic                  out_valid_q;
	logic [47:0]           out_data_q;
	logic                  out_user_q;
	logic                  out_last_q;

	logic                  in_range;
	logic [1:0]            ph;
	logic [3*N_BITS-1:0]   p3;
	logic [31:0]           v_sum;
	logic [N_BITS:0]       t;
	logic [N_BITS:0]       t_sub;
	logic [N_BITS-1:0]     rem_d;
	logic [19:0]           cval;
	logic [11:0]           crc_chk;
	logic                  len_ok;
	logic                  is_long;
	logic [2:0]            fin_status;
	logic                  fin_xvalid;
	logic [7:0]            fin_extra;

	assign in_range = {1'b0, w_q} < n_q;
	assign ph       = pos_phase(pos_q);
	assign p3       = prod_nn_q * d2_q;
	assign v_sum    = {{(32-INDEX_BITS){1'b0}}, h_q[0]} + {{(32-2*N_BITS){1'b0}}, prod_a_q}
		+ p3[31:0];
	assign t        = {rem_q, vsh_q[31]};
	assign t_sub    = t - {1'b0, n_q};
	assign rem_d    = (t >= {1'b0, n_q}) ? t_sub[N_BITS-1:0] : t[N_BITS-1:0];

	assign cval     = {{(20-INDEX_BITS){1'b0}}, h_q[0]} + prod_a_q[19:0];
	assign crc_chk  = crc_byte(crc_q, cval[7:0]);
	assign is_long  = pos_q == LONG_WORDS;
	assign len_ok   = (pos_q == GROUP_WORDS) || is_long;

	always_comb begin
		fin_xvalid = len_ok && (err_q == ST_OK) && is_long;
		fin_extra  = fin_xvalid ? cval[7:0] : 8'h00;
		if (!len_ok) begin
			fin_status = ST_BAD_LEN;
		end else if (err_q != ST_OK) begin
			fin_status = err_q;
		end else if (is_long && (crc_chk != cval[19:8])) begin
			fin_status = ST_CHECKSUM;
		end else begin
			fin_status = ST_OK;
		end
	end

	assign st.group     = (err_q == ST_OK) && (pos_q < GROUP_WORDS) && in_range && (ph == 2'd2);
	assign st.last      = last_q;
	assign st.mod_done  = mcnt_q == 5'd31;
	assign st.match     = rem_q == {1'b0, h_q[0]};
	assign st.crc_done  = bcnt_q == 2'd3;
	assign st.slot_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= RESET_LIST_SIZE;
		end else if (cfg_valid) begin
			n_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q    <= in_index;
			last_q <= in_last;
		end
		if (cmd.mul1) begin
			prod_a_q  <= n_q * digit_diff(n_q, h_q[0], h_q[1]);
			prod_nn_q <= n_q * n_q;
			d2_q      <= digit_diff(n_q, h_q[1], w_q);
		end
		if (cmd.mul2) begin
			v_q    <= v_sum;
			vsh_q  <= v_sum;
			rem_q  <= '0;
			mcnt_q <= '0;
			bcnt_q <= '0;
		end
		if (cmd.mod_step) begin
			rem_q  <= rem_d;
			vsh_q  <= {vsh_q[30:0], 1'b0};
			mcnt_q <= mcnt_q + 5'd1;
		end
		if (cmd.crc_step) begin
			bcnt_q <= bcnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			h_q[0] <= '0;
			h_q[1] <= '0;
			crc_q  <= '0;
			err_q  <= ST_OK;
		end else if (cmd.emit_final) begin
			pos_q  <= '0;
			h_q[0] <= '0;
			h_q[1] <= '0;
			crc_q  <= '0;
			err_q  <= ST_OK;
		end else begin
			if (cmd.classify) begin
				if (err_q == ST_OK) begin
					if (pos_q >= LONG_WORDS) begin
						err_q <= ST_BAD_LEN;
					end else if (!in_range) begin
						err_q <= ST_RANGE;
					end else if (pos_q < GROUP_WORDS) begin
						if (ph == 2'd0) h_q[0] <= w_q;
						if (ph == 2'd1) h_q[1] <= w_q;
					end else begin
						h_q[pos_q[0]] <= w_q;
					end
				end
				if (pos_q != MAX_POS) pos_q <= pos_q + 4'd1;
			end
			if (cmd.cmp_fail) err_q <= ST_GROUP;
			if (cmd.crc_step) crc_q <= crc_byte(crc_q, v_q[8*bcnt_q +: 8]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_key || cmd.emit_final) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_key) begin
			out_data_q <= {4'h0, ST_OK, 1'b0, 8'h00, v_q};
			out_user_q <= KIND_KEY;
			out_last_q <= !last_q;
		end else if (cmd.emit_final) begin
			out_data_q <= {4'h0, fin_status, fin_xvalid, fin_extra, 32'h0};
			out_user_q <= KIND_STATUS;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mod_step |-> rem_q < n_q) else $error("remainder out of bound");
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_key || cmd.emit_final) |-> st.slot_free) else $error("output overrun");
	a_seed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_final |=> (pos_q == 4'd0) && (err_q == ST_OK)) else $error("seed not cleared");
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		((err_q != ST_OK) && !cmd.emit_final) |=> $stable(err_q)) else $error("error not held");

endmodule

// ===== design/mnemonic_seed_decoder_core.sv =====
`timescale 1ns / 1ps
// A key word is presented after its third digit is accepted and passes the check, two
// multiply steps, the 32-step bit-serial remainder unit, compare and four CRC byte steps.
// A final status follows a closing word outside a group, a failed compare on a closing
// word, or the key word of a closing group, through the checksum and final steps.
// The input takes one index at a time and is ready again only when the controller is back
// in idle after a held digit, a group or a closing word; output stalls delay this further.
// Reset: arst_n clears all seed state and the output valid flag; list_size returns to 1626.
module mnemonic_seed_decoder_core import msd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // word_index[11:0]
	input  logic        s_tlast,  // end of seed
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // key_value[31:0], extra_value[39:32],
	                              // extra_valid[40], status_code[43:41]
	output logic        m_tuser,  // item_kind
	output logic        m_tlast   // run_end
);

	cmd_t  cmd;
	stat_t st;

	assign cfg_ready = 1'b1;

	msd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	msd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_index  (s_tdata[INDEX_BITS-1:0]),
		.in_last   (s_tlast),
		.cmd       (cmd),
		.st        (st),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import msd_pkg::*;

	typedef struct packed {
		logic        kind;
		logic [31:0] key;
		logic [7:0]  extra;
		logic        xvalid;
		logic [2:0]  status;
		logic        run_end;
	} seed_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [12:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	logic [12:0] base_n;
	logic [3:0]  word_pos;
	logic [11:0] digit_hold [2];
	logic [11:0] crc_acc;
	logic [2:0]  seed_err;
	seed_item_t  expected_items [$];
	int          mismatches = 0;
	bit          calm = 1'b0;

	mnemonic_seed_decoder_core i_dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#60ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [11:0] crc_add(input logic [11:0] c, input logic [7:0] d);
		logic [11:0] r;
		r = c ^ {d, 4'h0};
		for (int b = 0; b < 8; b++) begin
			r = r[11] ? ({r[10:0], 1'b0} ^ 12'h987) : {r[10:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic [31:0] mod_gap(input logic [31:0] n, input logic [31:0] a,
			input logic [31:0] b);
		return (n - a + b) % n;
	endfunction

	task automatic seed_reset_state();
		word_pos = '0;
		digit_hold[0] = '0;
		digit_hold[1] = '0;
		crc_acc = '0;
		seed_err = ST_OK;
	endtask

	task automatic expect_item(input seed_item_t it);
		expected_items.insert(expected_items.size(), it);
	endtask

	task automatic predict_word(input logic [11:0] w, input logic last);
		logic [31:0] n, v, w1, w2, c;
		logic [7:0] extra;
		logic xv;
		logic [2:0] st;
		seed_item_t it;
		n = {19'h0, base_n};
		if (seed_err == ST_OK) begin
			if (word_pos >= LONG_WORDS) begin
				seed_err = ST_BAD_LEN;
			end else if ({20'h0, w} >= n) begin
				seed_err = ST_RANGE;
			end else if (word_pos < GROUP_WORDS) begin
				if (word_pos % 3 < 2) begin
					digit_hold[word_pos % 3] = w;
				end else begin
					w1 = {20'h0, digit_hold[0]};
					w2 = {20'h0, digit_hold[1]};
					v = w1 + n * mod_gap(n, w1, w2) + n * n * mod_gap(n, w2, {20'h0, w});
					if (v % n != w1) begin
						seed_err = ST_GROUP;
					end else begin
						it = '{KIND_KEY, v, 8'h0, 1'b0, ST_OK, !last};
						expect_item(it);
						for (int i = 0; i < 4; i++) crc_acc = crc_add(crc_acc, v[8*i +: 8]);
					end
				end
			end else begin
				digit_hold[word_pos - GROUP_WORDS] = w;
			end
		end
		if (word_pos < MAX_POS) word_pos++;
		if (last) begin
			st = seed_err;
			extra = '0;
			xv = 1'b0;
			if (word_pos != GROUP_WORDS && word_pos != LONG_WORDS) begin
				st = ST_BAD_LEN;
			end else if (st == ST_OK && word_pos == LONG_WORDS) begin
				w1 = {20'h0, digit_hold[0]};
				w2 = {20'h0, digit_hold[1]};
				c = (w1 + n * mod_gap(n, w1, w2)) & 32'hfffff;
				extra = c[7:0];
				xv = 1'b1;
				if (crc_add(crc_acc, extra) != c[19:8]) st = ST_CHECKSUM;
			end
			it = '{KIND_STATUS, 32'h0, extra, xv, st, 1'b1};
			expect_item(it);
			seed_reset_state();
		end
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 17);
	end

	always @(posedge clk) begin
		seed_item_t e;
		if (m_tvalid && m_tready) begin
			if (expected_items.size() == 0) begin
				report("unexpected transaction", {16'h0, m_tdata}, 64'h0);
			end else begin
				e = expected_items.pop_front();
				if (m_tuser !== e.kind) report("item_kind", m_tuser, e.kind);
				if (m_tdata[31:0] !== e.key) report("key_value", m_tdata[31:0], e.key);
				if (m_tdata[39:32] !== e.extra) report("extra_value", m_tdata[39:32], e.extra);
				if (m_tdata[40] !== e.xvalid) report("extra_valid", m_tdata[40], e.xvalid);
				if (m_tdata[43:41] !== e.status) report("status_code", m_tdata[43:41], e.status);
				if (m_tlast !== e.run_end) report("run_end", m_tlast, e.run_end);
			end
		end
	end

	task automatic send_word(input logic [11:0] w, input logic last);
		while (!calm && $urandom_range(99) < 17) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'h0, w};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		predict_word(w, last);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (expected_items.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
	endtask

	task automatic write_list_size(input logic [12:0] n);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= n;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		base_n = n;
	endtask

	function automatic logic [11:0] pick_digit();
		int top;
		top = (base_n == 0) ? 0 : ((base_n > 4096) ? 4095 : int'(base_n) - 1);
		return (base_n != 0 && $urandom_range(99) < 95) ? 12'($urandom_range(top))
			: 12'($urandom);
	endfunction

	task automatic send_seed(input int len);
		for (int i = 0; i < len; i++) send_word(pick_digit(), i == len - 1);
	endtask

	// build a 14-word seed whose checksum pair matches whenever n*n is at least 2**20
	task automatic send_valid_long_seed();
		logic [31:0] n, c, v, d;
		logic [11:0] g [12];
		logic [11:0] cs, w1, w2;
		logic [7:0] extra;
		n = {19'h0, base_n};
		for (int i = 0; i < 12; i++) g[i] = 12'($urandom_range(n - 1));
		cs = 12'h0;
		for (int k = 0; k < 4; k++) begin
			v = g[3*k] + n * mod_gap(n, {20'h0, g[3*k]}, {20'h0, g[3*k+1]})
				+ n * n * mod_gap(n, {20'h0, g[3*k+1]}, {20'h0, g[3*k+2]});
			if (v % n == {20'h0, g[3*k]})
				for (int i = 0; i < 4; i++) cs = crc_add(cs, v[8*i +: 8]);
		end
		extra = 8'($urandom);
		c = {12'h0, crc_add(cs, extra), extra};
		w1 = 12'(c % n);
		d = (c / n) % n;
		w2 = 12'(({20'h0, w1} + d) % n);
		for (int i = 0; i < 12; i++) send_word(g[i], 1'b0);
		send_word(w1, 1'b0);
		send_word(w2, 1'b1);
	endtask

	task automatic test_directed();
		send_seed(12);
		send_seed(14);
		send_valid_long_seed();
		send_word(12'hfff, 1'b1);
		for (int i = 0; i < 3; i++) send_word(i == 0 ? 12'h000 : 12'hfff, i == 2);
		send_seed(15);
	endtask

	task automatic test_list_sizes();
		logic [12:0] sizes [6] = '{13'd2, 13'd4096, 13'd8191, 13'd0, 13'd3, 13'd2048};
		foreach (sizes[i]) begin
			write_list_size(sizes[i]);
			send_seed(12);
			send_seed(14);
		end
		write_list_size(13'd256);
		send_valid_long_seed();
	endtask

	task automatic test_random();
		int sent;
		sent = 0;
		while (sent < 720) begin
			int len;
			if (sent > 400 && sent < 520) calm = 1'b1;
			else calm = 1'b0;
			if (sent > 300 && sent < 330) drain();
			if ($urandom_range(99) < 20) len = $urandom_range(1, 17);
			else len = $urandom_range(1) ? 12 : 14;
			if ($urandom_range(9) < 3 && base_n >= 2 && base_n <= 4096) begin
				send_valid_long_seed();
				len = 14;
			end else begin
				send_seed(len);
			end
			sent += len;
			if ($urandom_range(99) < 3)
				write_list_size($urandom_range(99) < 50 ? 13'd1626
					: 13'($urandom_range(2, 4096)));
		end
		calm = 1'b0;
	endtask

	initial begin
		base_n = RESET_LIST_SIZE;
		seed_reset_state();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_list_sizes();
		write_list_size(RESET_LIST_SIZE);
		test_random();
		drain();
		if (mismatches == 0 && expected_items.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
